[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the partitioner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define NSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define NSP_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[hw/rtl/nsp_pkg.sv]
`timescale 1ns / 1ps
package nsp_pkg;

   localparam int MAX_DIMS_DEF   = 4;
   localparam int MAX_PIECES_DEF = 4096;

   localparam int DATA_W     = 32;
   localparam int DIVIDEND_W = 64;
   localparam int ID_W       = 12;
   localparam int TOTAL_W    = 13;
   localparam int ADDR_W     = 5;
   localparam int CNT_W      = 7;
   localparam int MCNT_W     = 6;

   typedef enum logic [2:0] {
      REG_DIM_COUNT    = 3'd0,
      REG_EXTENT_ZERO  = 3'd1,
      REG_EXTENT_ONE   = 3'd2,
      REG_EXTENT_TWO   = 3'd3,
      REG_EXTENT_THREE = 3'd4,
      REG_PIECE_SIZE   = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      DIV_BLOCKS = 3'd0,
      DIV_LEFT   = 3'd1,
      DIV_EXT    = 3'd2,
      DIV_ID     = 3'd3,
      DIV_MOD    = 3'd4
   } div_sel_type;

   typedef struct packed {
      logic        init_derive;
      logic        mul_start;
      logic        div_start;
      div_sel_type div_sel;
      logic        blocks_load;
      logic        split_short;
      logic        split_long;
      logic        left_load;
      logic        ext_load;
      logic        rp_init;
      logic        rp_step;
      logic        item_load;
      logic        bid_load;
      logic        prod_load;
      logic        out_load;
      logic        dim_clr;
      logic        dim_inc;
      logic        dim_dec;
      logic        dim_top;
   } cmd_type;

   typedef struct packed {
      logic cfg_wr;
      logic mul_busy;
      logic div_busy;
      logic dim_last;
      logic dim_zero;
      logic left_gt1;
      logic left_lt_ext;
      logic bad;
      logic out_free;
   } status_type;

endpackage

[hw/rtl/nd_subblock_partitioner_top.sv]
// Per item: for each dimension in use, two 12-step divides on the shared radix-2 divider,
// then the product and output-load states; an out-of-range id skips the divides and product.
// One item at a time; the next item is taken once the last result is loaded.
// After reset or a register write the split is derived again with req_stall high.
// Reset is synchronous and returns the configuration registers to one.
`timescale 1ns / 1ps
module nd_subblock_partitioner_top #(
   parameter int MAX_DIMS   = nsp_pkg::MAX_DIMS_DEF,
   parameter int MAX_PIECES = nsp_pkg::MAX_PIECES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [nsp_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [nsp_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [nsp_pkg::DATA_W-1:0]      csr_prdata,
   output logic                            csr_pready,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [nsp_pkg::ID_W-1:0]        req_piece_id,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_dim_index,
   output logic [nsp_pkg::DATA_W-1:0]      rsp_piece_start,
   output logic [nsp_pkg::DATA_W-1:0]      rsp_piece_extent,
   output logic [nsp_pkg::TOTAL_W-1:0]     rsp_total_pieces,
   output logic                            rsp_id_out_of_range,
   output logic                            rsp_last_dim
);
   import nsp_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;

   nsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nsp_dp #(
      .MAX_DIMS   (MAX_DIMS),
      .MAX_PIECES (MAX_PIECES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .req_piece_id        (req_piece_id),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_dim_index       (rsp_dim_index),
      .rsp_piece_start     (rsp_piece_start),
      .rsp_piece_extent    (rsp_piece_extent),
      .rsp_total_pieces    (rsp_total_pieces),
      .rsp_id_out_of_range (rsp_id_out_of_range),
      .rsp_last_dim        (rsp_last_dim),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

[hw/rtl/nsp_div.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nsp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [nsp_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [nsp_pkg::DATA_W-1:0]        divisor,
   input  logic [nsp_pkg::CNT_W-1:0]         steps,
   output logic                              busy,
   output logic [nsp_pkg::DIVIDEND_W-1:0]    quotient,
   output logic [nsp_pkg::DATA_W-1:0]        remainder
);
   import nsp_pkg::*;

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0]     rem_ff, rem_in;
   logic [DATA_W-1:0]     dsr_ff, dsr_in;
   logic [DATA_W:0]       trial;
   logic                  ge;

   // One restoring step per cycle; dividend bits enter from the top of quo
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? DATA_W'(trial - {1'b0, dsr_ff}) : trial[DATA_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   `NSP_ASSERT(a_div_busy_after_start, clock, reset, start |=> busy_ff, "divider idle after start")

endmodule

[hw/rtl/nsp_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  nsp_pkg::status_type status,
   output nsp_pkg::cmd_type    cmd
);
   import nsp_pkg::*;

   typedef enum logic [16:0] {
      ST_INIT      = 17'h00001,
      ST_MUL_GO    = 17'h00002,
      ST_MUL_WAIT  = 17'h00004,
      ST_BLK_GO    = 17'h00008,
      ST_BLK_WAIT  = 17'h00010,
      ST_SPLIT     = 17'h00020,
      ST_LEFT_WAIT = 17'h00040,
      ST_REM_GO    = 17'h00080,
      ST_REM_WAIT  = 17'h00100,
      ST_RP        = 17'h00200,
      ST_IDLE      = 17'h00400,
      ST_ITEM      = 17'h00800,
      ST_ID_WAIT   = 17'h01000,
      ST_MOD_WAIT  = 17'h02000,
      ST_PROD      = 17'h04000,
      ST_EMIT      = 17'h08000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE) || status.cfg_wr;
   assign accept    = req_valid && !req_stall;

   // Sequence derivation after reset or a register write, then serve items
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      if (status.cfg_wr) begin
         state_in = ST_INIT;
      end else begin
         unique case (state_ff)
            ST_INIT: begin
               cmd.init_derive = 1'b1;
               cmd.dim_clr     = 1'b1;
               state_in        = ST_MUL_GO;
            end
            ST_MUL_GO: begin
               cmd.mul_start = 1'b1;
               state_in      = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
               if (!status.mul_busy) begin
                  if (status.dim_last) begin
                     cmd.dim_clr = 1'b1;
                     state_in    = ST_BLK_GO;
                  end else begin
                     cmd.dim_inc = 1'b1;
                     state_in    = ST_MUL_GO;
                  end
               end
            end
            ST_BLK_GO: begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_BLOCKS;
               state_in      = ST_BLK_WAIT;
            end
            ST_BLK_WAIT: begin
               if (!status.div_busy) begin
                  cmd.blocks_load = 1'b1;
                  state_in        = ST_SPLIT;
               end
            end
            ST_SPLIT: begin
               priority if (!status.left_gt1) begin
                  cmd.dim_clr = 1'b1;
                  state_in    = ST_REM_GO;
               end else if (status.left_lt_ext) begin
                  cmd.split_short = 1'b1;
                  cmd.dim_clr     = 1'b1;
                  state_in        = ST_REM_GO;
               end else begin
                  cmd.split_long = 1'b1;
                  cmd.div_start  = 1'b1;
                  cmd.div_sel    = DIV_LEFT;
                  state_in       = ST_LEFT_WAIT;
               end
            end
            ST_LEFT_WAIT: begin
               if (!status.div_busy) begin
                  cmd.left_load = 1'b1;
                  if (status.dim_last) begin
                     cmd.dim_clr = 1'b1;
                     state_in    = ST_REM_GO;
                  end else begin
                     cmd.dim_inc = 1'b1;
                     state_in    = ST_SPLIT;
                  end
               end
            end
            ST_REM_GO: begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_EXT;
               state_in      = ST_REM_WAIT;
            end
            ST_REM_WAIT: begin
               if (!status.div_busy) begin
                  cmd.ext_load = 1'b1;
                  if (status.dim_last) begin
                     cmd.dim_top = 1'b1;
                     cmd.rp_init = 1'b1;
                     state_in    = ST_RP;
                  end else begin
                     cmd.dim_inc = 1'b1;
                     state_in    = ST_REM_GO;
                  end
               end
            end
            ST_RP: begin
               cmd.rp_step = 1'b1;
               if (status.dim_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.dim_dec = 1'b1;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  cmd.item_load = 1'b1;
                  cmd.dim_clr   = 1'b1;
                  state_in      = ST_ITEM;
               end
            end
            ST_ITEM: begin
               if (status.bad) begin
                  state_in = ST_EMIT;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_ID;
                  state_in      = ST_ID_WAIT;
               end
            end
            ST_ID_WAIT: begin
               if (!status.div_busy) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_MOD;
                  state_in      = ST_MOD_WAIT;
               end
            end
            ST_MOD_WAIT: begin
               if (!status.div_busy) begin
                  cmd.bid_load = 1'b1;
                  state_in     = ST_PROD;
               end
            end
            ST_PROD: begin
               cmd.prod_load = 1'b1;
               state_in      = ST_EMIT;
            end
            ST_EMIT: begin
               if (status.out_free) begin
                  cmd.out_load = 1'b1;
                  if (status.dim_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.dim_inc = 1'b1;
                     state_in    = ST_ITEM;
                  end
               end
            end
            default: begin
               state_in = ST_INIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   `NSP_ASSERT(a_accept_starts_item, clock, reset, accept |=> (state_ff == ST_ITEM || state_ff == ST_INIT), "accepted item not started")
   `NSP_NEVER(a_one_unit_start, clock, reset, cmd.mul_start && cmd.div_start, "multiplier and divider started together")

endmodule

[hw/rtl/nsp_dp.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nsp_dp #(
   parameter int MAX_DIMS   = nsp_pkg::MAX_DIMS_DEF,
   parameter int MAX_PIECES = nsp_pkg::MAX_PIECES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [nsp_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [nsp_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [nsp_pkg::DATA_W-1:0]      csr_prdata,
   input  logic [nsp_pkg::ID_W-1:0]        req_piece_id,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_dim_index,
   output logic [nsp_pkg::DATA_W-1:0]      rsp_piece_start,
   output logic [nsp_pkg::DATA_W-1:0]      rsp_piece_extent,
   output logic [nsp_pkg::TOTAL_W-1:0]     rsp_total_pieces,
   output logic                            rsp_id_out_of_range,
   output logic                            rsp_last_dim,
   input  nsp_pkg::cmd_type                cmd,
   output nsp_pkg::status_type             status
);
   import nsp_pkg::*;

   localparam int PW   = $clog2(MAX_PIECES + 1);
   localparam int DIW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CMPW = (PW > ID_W) ? PW : ID_W;

   // Configuration registers
   logic [2:0]        dimc_ff;
   logic [DATA_W-1:0] ext_ff [4];
   logic [DATA_W-1:0] psz_ff;
   logic              cfg_wr;
   csr_reg_type       cfg_idx;

   // Derived state
   logic [DIVIDEND_W-1:0] elems_ff;
   logic [PW-1:0]         left_ff;
   logic [PW-1:0]         prod_ff;
   logic [PW-1:0]         sf_ff   [MAX_DIMS];
   logic [PW-1:0]         rm_ff   [MAX_DIMS];
   logic [PW-1:0]         rp_ff   [MAX_DIMS];
   logic [DATA_W-1:0]     base_ff [MAX_DIMS];
   logic [DIW-1:0]        dim_ff;

   // Per-item working registers
   logic [ID_W-1:0]   id_ff;
   logic              bad_ff;
   logic [ID_W-1:0]   bid_ff;
   logic [DATA_W-1:0] startp_ff;

   // Serial multiplier
   logic [DIVIDEND_W-1:0] macc_ff, macc_in;
   logic [DATA_W-1:0]     mplr_ff, mplr_in;
   logic                  msat_ff, msat_in;
   logic [MCNT_W-1:0]     mcnt_ff;
   logic                  mbusy_ff;
   logic [DIVIDEND_W:0]   msum;
   logic [DIVIDEND_W-1:0] maddend;

   // Output register
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_dim_ff;
   logic [DATA_W-1:0]     rsp_start_ff;
   logic [DATA_W-1:0]     rsp_ext_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;
   logic                  rsp_oor_ff;
   logic                  rsp_last_ff;

   // Divider hookup
   logic [DIVIDEND_W-1:0] dvd;
   logic [DATA_W-1:0]     dsr;
   logic [CNT_W-1:0]      dsteps;
   logic                  div_busy;
   logic [DIVIDEND_W-1:0] div_quo;
   logic [DATA_W-1:0]     div_rem;

   logic [3:0]        nd4;
   logic              dim_last;
   logic [2:0]        dim3;
   logic [DATA_W-1:0] ext_cur;
   logic [PW-1:0]     sf_cur;
   logic [PW-1:0]     rm_cur;
   logic [PW-1:0]     rp_cur;
   logic [DATA_W-1:0] base_cur;
   logic [PW-1:0]     blocks;
   logic              lt;
   logic              out_free;

   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_idx = csr_reg_type'(csr_paddr[ADDR_W-1:2]);

   // Register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dimc_ff <= 3'd1;
         for (int i = 0; i < 4; i++) begin
            ext_ff[i] <= DATA_W'(1);
         end
         psz_ff <= DATA_W'(1);
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_DIM_COUNT:    dimc_ff   <= csr_pwdata[2:0];
            REG_EXTENT_ZERO:  ext_ff[0] <= csr_pwdata;
            REG_EXTENT_ONE:   ext_ff[1] <= csr_pwdata;
            REG_EXTENT_TWO:   ext_ff[2] <= csr_pwdata;
            REG_EXTENT_THREE: ext_ff[3] <= csr_pwdata;
            REG_PIECE_SIZE:   psz_ff    <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   // Register file reads
   always_comb begin
      unique case (cfg_idx)
         REG_DIM_COUNT:    csr_prdata = DATA_W'(dimc_ff);
         REG_EXTENT_ZERO:  csr_prdata = ext_ff[0];
         REG_EXTENT_ONE:   csr_prdata = ext_ff[1];
         REG_EXTENT_TWO:   csr_prdata = ext_ff[2];
         REG_EXTENT_THREE: csr_prdata = ext_ff[3];
         REG_PIECE_SIZE:   csr_prdata = psz_ff;
         default:          csr_prdata = '0;
      endcase
   end

   // Clamp the dimension count and pick the current dimension's values
   always_comb begin
      if (dimc_ff == 3'd0) begin
         nd4 = 4'd1;
      end else if (4'(dimc_ff) > 4'(MAX_DIMS)) begin
         nd4 = 4'(MAX_DIMS);
      end else begin
         nd4 = 4'(dimc_ff);
      end
      dim_last = 4'(dim_ff) == (nd4 - 4'd1);
      dim3     = 3'(dim_ff);
      ext_cur  = (dim3 < 3'd4) ? ext_ff[dim3[1:0]] : DATA_W'(1);
      sf_cur   = sf_ff[dim_ff];
      rm_cur   = rm_ff[dim_ff];
      rp_cur   = rp_ff[dim_ff];
      base_cur = base_ff[dim_ff];
   end

   // Divider operand select
   always_comb begin
      unique case (cmd.div_sel)
         DIV_BLOCKS: begin
            dvd    = elems_ff;
            dsr    = (psz_ff == '0) ? DATA_W'(1) : psz_ff;
            dsteps = CNT_W'(DIVIDEND_W);
         end
         DIV_LEFT: begin
            dvd    = DIVIDEND_W'(left_ff) << (DIVIDEND_W - PW);
            dsr    = ext_cur;
            dsteps = CNT_W'(PW);
         end
         DIV_EXT: begin
            dvd    = {ext_cur, {(DIVIDEND_W-DATA_W){1'b0}}};
            dsr    = DATA_W'(sf_cur);
            dsteps = CNT_W'(DATA_W);
         end
         DIV_ID: begin
            dvd    = {id_ff, {(DIVIDEND_W-ID_W){1'b0}}};
            dsr    = DATA_W'(rp_cur);
            dsteps = CNT_W'(ID_W);
         end
         DIV_MOD: begin
            dvd    = {div_quo[ID_W-1:0], {(DIVIDEND_W-ID_W){1'b0}}};
            dsr    = DATA_W'(sf_cur);
            dsteps = CNT_W'(ID_W);
         end
         default: begin
            dvd    = elems_ff;
            dsr    = DATA_W'(1);
            dsteps = CNT_W'(1);
         end
      endcase
   end

   nsp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dvd),
      .divisor   (dsr),
      .steps     (dsteps),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Sub-block count: ceiling of the quotient, clamped to 1..MAX_PIECES
   always_comb begin
      if (div_quo >= DIVIDEND_W'(MAX_PIECES)) begin
         blocks = PW'(MAX_PIECES);
      end else begin
         blocks = PW'(div_quo) + PW'(div_rem != '0);
      end
      if (blocks == '0) begin
         blocks = PW'(1);
      end
   end

   // Saturating multiply, one multiplier bit per cycle from the top
   always_comb begin
      maddend = mplr_ff[DATA_W-1] ? elems_ff : '0;
      msum    = {1'b0, macc_ff[DIVIDEND_W-2:0], 1'b0} + {1'b0, maddend};
      msat_in = msat_ff | macc_ff[DIVIDEND_W-1] | msum[DIVIDEND_W];
      macc_in = msum[DIVIDEND_W-1:0];
      mplr_in = {mplr_ff[DATA_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
      end else if (cmd.mul_start) begin
         mbusy_ff <= 1'b1;
      end else if (mbusy_ff && mcnt_ff == MCNT_W'(1)) begin
         mbusy_ff <= 1'b0;
      end
      if (cmd.mul_start) begin
         macc_ff <= '0;
         msat_ff <= 1'b0;
         mplr_ff <= ext_cur;
         mcnt_ff <= MCNT_W'(DATA_W);
      end else if (mbusy_ff) begin
         macc_ff <= macc_in;
         msat_ff <= msat_in;
         mplr_ff <= mplr_in;
         mcnt_ff <= mcnt_ff - 1'b1;
      end
   end

   // Element count: start at one, fold in each product
   always_ff @(posedge clock) begin
      if (cmd.init_derive) begin
         elems_ff <= DIVIDEND_W'(1);
      end else if (mbusy_ff && mcnt_ff == MCNT_W'(1)) begin
         elems_ff <= msat_in ? '1 : macc_in;
      end
   end

   // Split factors, remainders, reverse products
   always_ff @(posedge clock) begin
      if (cmd.init_derive) begin
         for (int i = 0; i < MAX_DIMS; i++) begin
            sf_ff[i]   <= PW'(1);
            rm_ff[i]   <= '0;
            rp_ff[i]   <= PW'(1);
            base_ff[i] <= DATA_W'(1);
         end
      end
      if (cmd.blocks_load) begin
         left_ff <= blocks;
      end
      if (cmd.split_short) begin
         sf_ff[dim_ff] <= left_ff;
         left_ff       <= PW'(1);
      end
      if (cmd.split_long) begin
         sf_ff[dim_ff] <= PW'(ext_cur);
      end
      if (cmd.left_load) begin
         left_ff <= div_quo[PW-1:0];
      end
      if (cmd.ext_load) begin
         rm_ff[dim_ff]   <= div_rem[PW-1:0];
         base_ff[dim_ff] <= div_quo[DATA_W-1:0];
      end
      if (cmd.rp_init) begin
         prod_ff <= PW'(1);
      end
      if (cmd.rp_step) begin
         rp_ff[dim_ff] <= prod_ff;
         prod_ff       <= PW'(prod_ff * sf_cur);
      end
   end

   // Dimension counter
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= '0;
      end else if (cmd.dim_clr) begin
         dim_ff <= '0;
      end else if (cmd.dim_top) begin
         dim_ff <= DIW'(nd4 - 4'd1);
      end else if (cmd.dim_inc) begin
         dim_ff <= dim_ff + 1'b1;
      end else if (cmd.dim_dec) begin
         dim_ff <= dim_ff - 1'b1;
      end
   end

   // Item working registers
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         id_ff  <= req_piece_id;
         bad_ff <= CMPW'(req_piece_id) >= CMPW'(prod_ff);
      end
      if (cmd.bid_load) begin
         bid_ff <= div_rem[ID_W-1:0];
      end
      if (cmd.prod_load) begin
         startp_ff <= DATA_W'(base_cur * bid_ff);
      end
   end

   // Output register: hold until the transfer completes
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign lt       = CMPW'(bid_ff) < CMPW'(rm_cur);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_dim_ff   <= 2'(dim_ff);
         rsp_total_ff <= TOTAL_W'(prod_ff);
         rsp_oor_ff   <= bad_ff;
         rsp_last_ff  <= dim_last;
         if (bad_ff) begin
            rsp_start_ff <= '0;
            rsp_ext_ff   <= '0;
         end else begin
            rsp_start_ff <= startp_ff + (lt ? DATA_W'(bid_ff) : DATA_W'(rm_cur));
            rsp_ext_ff   <= base_cur + DATA_W'(lt);
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_dim_index       = rsp_dim_ff;
   assign rsp_piece_start     = rsp_start_ff;
   assign rsp_piece_extent    = rsp_ext_ff;
   assign rsp_total_pieces    = rsp_total_ff;
   assign rsp_id_out_of_range = rsp_oor_ff;
   assign rsp_last_dim        = rsp_last_ff;

   always_comb begin
      status             = '0;
      status.cfg_wr      = cfg_wr;
      status.mul_busy    = mbusy_ff;
      status.div_busy    = div_busy;
      status.dim_last    = dim_last;
      status.dim_zero    = dim_ff == '0;
      status.left_gt1    = left_ff > PW'(1);
      status.left_lt_ext = DATA_W'(left_ff) < ext_cur;
      status.bad         = bad_ff;
      status.out_free    = out_free;
   end

   `NSP_ASSERT(a_oor_zero, clock, reset, (rsp_valid_ff && rsp_oor_ff) |-> (rsp_start_ff == '0 && rsp_ext_ff == '0), "out-of-range result not zero")
   `NSP_ASSERT(a_load_when_free, clock, reset, cmd.out_load |-> out_free, "result overwritten before transfer")

endmodule
